@@ rtl/core/lprr_pkg.sv @@
// lprr_pkg: sizes, codes and transfer types of the length-prefixed record ring
// no dependencies; imported by length_prefixed_record_ring and tb_top
package lprr_pkg;

    localparam int RING_BYTES   = 65536;
    localparam int MAX_RECORD   = 4096;
    localparam int HEADER_BYTES = 2;

    localparam int WR_LENGTH_W = 16;
    localparam int RD_LIMIT_W  = 13;

    localparam int ADDR_W = $clog2(RING_BYTES);
    localparam int OCC_W  = $clog2(RING_BYTES + 1);
    localparam int LEN_W  = $clog2(MAX_RECORD + 1);
    localparam int SIZE_W = $clog2(MAX_RECORD + HEADER_BYTES + 1);
    localparam int HDR_W  = 8 * HEADER_BYTES;
    localparam int HC_W   = $clog2(HEADER_BYTES);
    localparam int CMP_W  = HDR_W + OCC_W;
    localparam int MIN_W  = (LEN_W > RD_LIMIT_W) ? LEN_W : RD_LIMIT_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DELIVERED = 3'd1;
    localparam logic [2:0] STAT_DROPPED   = 3'd2;
    localparam logic [2:0] STAT_EMPTY     = 3'd3;
    localparam logic [2:0] STAT_CORRUPT   = 3'd4;

    typedef struct packed {
        logic                   opcode;
        logic [7:0]             wr_byte;
        logic                   wr_first;
        logic [WR_LENGTH_W-1:0] wr_length;
        logic                   rd_first;
        logic [RD_LIMIT_W-1:0]  rd_limit;
    } req_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       committed;
        logic [2:0] status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WHDR,
        ST_WDATA,
        ST_RHDR,
        ST_RCHECK,
        ST_RDATA,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/length_prefixed_record_ring.sv @@
// length_prefixed_record_ring: byte ring of length-prefixed records in one
// synchronous memory, with a sequencer for header and data transfers
// depends on lprr_pkg
//
//   channel | role   | payload | handshake
//   req     | input  | req_t   | req_valid / req_ready
//   rsp     | output | rsp_t   | rsp_valid / rsp_ready
//
// one item at a time; the single memory port per side moves one header byte
// per cycle, and the data read from the ring memory is registered
// reset clears pointers, counts and control; the ring memory is not cleared
// a finished result moves into the output register, after which the next
// request is taken; a full output register holds the sequencer in its last step
module length_prefixed_record_ring
    import lprr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic [7:0] ring_mem [RING_BYTES];
    logic [7:0] mem_q_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t state_reg, state_next;
    req_t   item_reg, item_next;
    rsp_t   res_reg, res_next;
    rsp_t   out_reg, out_next;
    logic   out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [LEN_W-1:0]  wleft_reg, wleft_next;
    logic              wdrop_reg, wdrop_next;
    logic [ADDR_W-1:0] wcur_reg, wcur_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [LEN_W-1:0]  rleft_reg, rleft_next;
    logic [ADDR_W-1:0] rend_reg, rend_next;
    logic [ADDR_W-1:0] rcur_reg, rcur_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;
    logic [HC_W-1:0]   hcnt_reg, hcnt_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;

    logic              slot_free;
    logic              hcnt_last;
    logic [LEN_W-1:0]  len_trunc;
    logic [OCC_W:0]    need_w;
    logic [OCC_W:0]    free_w;
    logic              no_fit;
    logic              rd_busy;
    logic [OCC_W-1:0]  occ_rel;
    logic [OCC_W-1:0]  occ_eff;
    logic [ADDR_W-1:0] rp_eff;
    logic              ring_empty;
    logic              corrupt;
    logic [LEN_W-1:0]  hdr_len;
    logic [SIZE_W-1:0] new_size;
    logic [ADDR_W-1:0] new_end;
    logic [MIN_W-1:0]  deliver;
    logic [SIZE_W-1:0] wsize;
    logic [HDR_W-1:0]  wlen_word;

    // decode
    assign slot_free = !out_valid_reg || rsp_ready;
    assign hcnt_last = (hcnt_reg == HC_W'(HEADER_BYTES - 1));
    assign len_trunc = (item_reg.wr_length > WR_LENGTH_W'(MAX_RECORD)) ?
                       LEN_W'(MAX_RECORD) : LEN_W'(item_reg.wr_length);
    assign need_w    = (OCC_W+1)'(len_trunc) + (OCC_W+1)'(HEADER_BYTES);
    assign free_w    = (OCC_W+1)'(RING_BYTES) - (OCC_W+1)'(occ_reg);
    assign no_fit    = need_w > free_w;
    assign rd_busy   = (rleft_reg != '0);
    assign occ_rel   = (occ_reg >= OCC_W'(rsize_reg)) ? occ_reg - OCC_W'(rsize_reg) : '0;
    assign occ_eff   = rd_busy ? occ_rel : occ_reg;
    assign rp_eff    = rd_busy ? rend_reg : rp_reg;
    assign ring_empty = occ_eff < OCC_W'(HEADER_BYTES);
    assign corrupt   = (CMP_W'(hdr_reg) > CMP_W'(MAX_RECORD)) ||
                       (CMP_W'(hdr_reg) > CMP_W'(occ_reg - OCC_W'(HEADER_BYTES)));
    assign hdr_len   = LEN_W'(hdr_reg);
    assign new_size  = SIZE_W'(hdr_len) + SIZE_W'(HEADER_BYTES);
    assign new_end   = rp_reg + ADDR_W'(new_size);
    assign deliver   = (MIN_W'(hdr_len) < MIN_W'(item_reg.rd_limit)) ?
                       MIN_W'(hdr_len) : MIN_W'(item_reg.rd_limit);
    assign wsize     = SIZE_W'(wlen_reg) + SIZE_W'(HEADER_BYTES);
    assign wlen_word = HDR_W'(wlen_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (item_reg.opcode == OP_WRITE)
                begin
                    if (item_reg.wr_first)
                        state_next = (len_trunc == '0 || no_fit) ? ST_DONE : ST_WHDR;
                    else
                        state_next = (wleft_reg == '0 || wdrop_reg) ? ST_DONE : ST_WDATA;
                end
                else
                begin
                    if (item_reg.rd_first)
                        state_next = ring_empty ? ST_DONE : ST_RHDR;
                    else
                        state_next = rd_busy ? ST_RDATA : ST_DONE;
                end
            end
            ST_WHDR:
            begin
                if (hcnt_last)
                    state_next = ST_WDATA;
            end
            ST_RHDR:
            begin
                if (hcnt_last)
                    state_next = ST_RCHECK;
            end
            ST_RCHECK:
            begin
                state_next = (corrupt || deliver == '0) ? ST_DONE : ST_RDATA;
            end
            ST_WDATA,
            ST_RDATA:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        occ_next       = occ_reg;
        wleft_next     = wleft_reg;
        wdrop_next     = wdrop_reg;
        wcur_next      = wcur_reg;
        wlen_next      = wlen_reg;
        rleft_next     = rleft_reg;
        rend_next      = rend_reg;
        rcur_next      = rcur_reg;
        rsize_next     = rsize_reg;
        hcnt_next      = hcnt_reg;
        hdr_next       = hdr_reg;
        mem_we         = 1'b0;
        mem_waddr      = wcur_reg;
        mem_wdata      = item_reg.wr_byte;
        mem_raddr      = rcur_reg;

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                end
            end
            ST_EXEC:
            begin
                if (item_reg.opcode == OP_WRITE)
                begin
                    if (item_reg.wr_first)
                    begin
                        wleft_next = '0;
                        wdrop_next = 1'b0;
                        if (len_trunc == '0)
                            res_next.status = STAT_OK;
                        else if (no_fit)
                        begin
                            wleft_next      = len_trunc - LEN_W'(1);
                            wdrop_next      = (len_trunc != LEN_W'(1));
                            res_next.status = STAT_DROPPED;
                        end
                        else
                        begin
                            wlen_next  = len_trunc;
                            wleft_next = len_trunc;
                            wcur_next  = wp_reg + ADDR_W'(HEADER_BYTES);
                            hcnt_next  = '0;
                        end
                    end
                    else if (wleft_reg != '0 && wdrop_reg)
                    begin
                        wleft_next = wleft_reg - LEN_W'(1);
                        if (wleft_reg == LEN_W'(1))
                            wdrop_next = 1'b0;
                        res_next.status = STAT_DROPPED;
                    end
                end
                else
                begin
                    if (item_reg.rd_first)
                    begin
                        // release the record still open
                        if (rd_busy)
                        begin
                            rp_next    = rend_reg;
                            occ_next   = occ_rel;
                            rleft_next = '0;
                        end
                        if (ring_empty)
                            res_next.status = STAT_EMPTY;
                        mem_raddr = rp_eff;
                        hcnt_next = '0;
                    end
                    else
                        mem_raddr = rcur_reg;
                end
            end
            ST_WHDR:
            begin
                mem_we    = 1'b1;
                mem_waddr = wp_reg + ADDR_W'(hcnt_reg);
                mem_wdata = wlen_word[8*hcnt_reg +: 8];
                hcnt_next = hcnt_reg + HC_W'(1);
            end
            ST_WDATA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wcur_reg;
                wcur_next  = wcur_reg + ADDR_W'(1);
                wleft_next = wleft_reg - LEN_W'(1);
                if (wleft_reg == LEN_W'(1))
                begin
                    wp_next            = wp_reg + ADDR_W'(wsize);
                    occ_next           = occ_reg + OCC_W'(wsize);
                    res_next.committed = 1'b1;
                end
            end
            ST_RHDR:
            begin
                hdr_next[8*hcnt_reg +: 8] = mem_q_reg;
                mem_raddr = rp_reg + ADDR_W'(hcnt_reg) + ADDR_W'(1);
                hcnt_next = hcnt_reg + HC_W'(1);
            end
            ST_RCHECK:
            begin
                if (corrupt)
                begin
                    rp_next         = wp_reg;
                    occ_next        = '0;
                    rleft_next      = '0;
                    res_next.status = STAT_CORRUPT;
                end
                else
                begin
                    rsize_next = new_size;
                    rend_next  = new_end;
                    rcur_next  = rp_reg + ADDR_W'(HEADER_BYTES);
                    mem_raddr  = rp_reg + ADDR_W'(HEADER_BYTES);
                    if (deliver == '0)
                    begin
                        rp_next          = new_end;
                        occ_next         = occ_reg - OCC_W'(new_size);
                        res_next.rd_last = 1'b1;
                    end
                    else
                        rleft_next = LEN_W'(deliver);
                end
            end
            ST_RDATA:
            begin
                res_next.rd_byte  = mem_q_reg;
                res_next.rd_valid = 1'b1;
                res_next.status   = STAT_DELIVERED;
                rcur_next         = rcur_reg + ADDR_W'(1);
                rleft_next        = rleft_reg - LEN_W'(1);
                if (rleft_reg == LEN_W'(1))
                begin
                    rp_next          = rend_reg;
                    occ_next         = occ_rel;
                    res_next.rd_last = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ring memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= ring_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            occ_reg       <= '0;
            wleft_reg     <= '0;
            wdrop_reg     <= 1'b0;
            wcur_reg      <= '0;
            wlen_reg      <= '0;
            rleft_reg     <= '0;
            rend_reg      <= '0;
            rcur_reg      <= '0;
            rsize_reg     <= '0;
            hcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            occ_reg       <= occ_next;
            wleft_reg     <= wleft_next;
            wdrop_reg     <= wdrop_next;
            wcur_reg      <= wcur_next;
            wlen_reg      <= wlen_next;
            rleft_reg     <= rleft_next;
            rend_reg      <= rend_next;
            rcur_reg      <= rcur_next;
            rsize_reg     <= rsize_next;
            hcnt_reg      <= hcnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        hdr_reg  <= hdr_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(RING_BYTES))
        else $error("occupancy above ring size");

    a_rleft_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rleft_reg <= LEN_W'(MAX_RECORD))
        else $error("read count above max record");

    a_deliver_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rd_valid |-> out_reg.status == STAT_DELIVERED)
        else $error("delivered byte without delivered status");

    a_commit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WDATA && wleft_reg == LEN_W'(1)
        |=> wp_reg == $past(wp_reg + ADDR_W'(wsize)) && res_reg.committed)
        else $error("commit did not advance write pointer");

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for length_prefixed_record_ring, byte transfers
// through valid/ready, every rsp transfer compared with a scripted result or a built-in ring predictor
// depends on lprr_pkg and length_prefixed_record_ring
module tb_top
    import lprr_pkg::*;
();

    localparam int SCRIPT_ROWS  = 26;
    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_PCT     = 22;

    typedef struct packed {
        req_t item;
        logic known;
        rsp_t want;
    } step_t;

    localparam rsp_t NO_RSP = '0;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic calm = 1'b0;
    int unsigned mismatches = 0;
    rsp_t awaited_rsp [$];
    step_t script [SCRIPT_ROWS];

    // ring predictor state
    logic [7:0]        ring_mem [RING_BYTES];
    logic [ADDR_W-1:0] wr_ptr     = '0;
    logic [ADDR_W-1:0] rd_ptr     = '0;
    logic [OCC_W-1:0]  fill_level = '0;
    logic [LEN_W-1:0]  wr_left    = '0;
    logic              wr_skip    = 1'b0;
    logic [ADDR_W-1:0] wr_pos     = '0;
    logic [LEN_W-1:0]  wr_len     = '0;
    logic [MIN_W-1:0]  rd_left    = '0;
    logic [ADDR_W-1:0] rd_next    = '0;
    logic [ADDR_W-1:0] rd_pos     = '0;
    logic [SIZE_W-1:0] rd_span    = '0;

    length_prefixed_record_ring dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("length_prefixed_record_ring regression: fail");
        $finish;
    end

    function automatic req_t wr_op(logic first, int unsigned length, logic [7:0] data);
        req_t it;
        it = '0;
        it.opcode    = OP_WRITE;
        it.wr_first  = first;
        it.wr_length = length[WR_LENGTH_W-1:0];
        it.wr_byte   = data;
        return it;
    endfunction

    function automatic req_t rd_op(logic first, int unsigned limit);
        req_t it;
        it = '0;
        it.opcode   = OP_READ;
        it.rd_first = first;
        it.rd_limit = limit[RD_LIMIT_W-1:0];
        return it;
    endfunction

    function automatic rsp_t outcome(logic [7:0] data, logic valid, logic last, logic done,
                                     logic [2:0] code);
        rsp_t r;
        r.rd_byte   = data;
        r.rd_valid  = valid;
        r.rd_last   = last;
        r.committed = done;
        r.status    = code;
        return r;
    endfunction

    function automatic void release_record();
        rd_ptr     = rd_next;
        fill_level = (fill_level >= rd_span) ? OCC_W'(fill_level - rd_span) : '0;
        rd_left    = '0;
    endfunction

    function automatic rsp_t ring_response(req_t item);
        rsp_t             r;
        logic [LEN_W-1:0] len;
        logic [HDR_W-1:0] hdr;
        logic [MIN_W-1:0] deliver;
        r = '0;
        if (item.opcode == OP_WRITE)
        begin
            if (item.wr_first)
            begin
                wr_left = '0;
                wr_skip = 1'b0;
                len = (item.wr_length > MAX_RECORD) ? LEN_W'(MAX_RECORD)
                                                    : LEN_W'(item.wr_length);
                if (len == 0)
                    return r;
                if (len + HEADER_BYTES > RING_BYTES - fill_level)
                begin
                    wr_left   = len - 1'b1;
                    wr_skip   = (wr_left != 0);
                    r.status  = STAT_DROPPED;
                    return r;
                end
                for (int i = 0; i < HEADER_BYTES; i++)
                    ring_mem[ADDR_W'(wr_ptr + i)] = 8'(len >> (8 * i));
                wr_pos  = ADDR_W'(wr_ptr + HEADER_BYTES);
                wr_len  = len;
                wr_left = len;
            end
            else if (wr_left == 0)
                return r;
            else if (wr_skip)
            begin
                wr_left = wr_left - 1'b1;
                if (wr_left == 0)
                    wr_skip = 1'b0;
                r.status = STAT_DROPPED;
                return r;
            end
            ring_mem[wr_pos] = item.wr_byte;
            wr_pos  = wr_pos + 1'b1;
            wr_left = wr_left - 1'b1;
            if (wr_left == 0)
            begin
                wr_ptr      = ADDR_W'(wr_ptr + HEADER_BYTES + wr_len);
                fill_level  = OCC_W'(fill_level + HEADER_BYTES + wr_len);
                r.committed = 1'b1;
            end
            return r;
        end
        if (item.rd_first)
        begin
            if (rd_left != 0)
                release_record();
            if (fill_level < HEADER_BYTES)
            begin
                r.status = STAT_EMPTY;
                return r;
            end
            hdr = '0;
            for (int i = 0; i < HEADER_BYTES; i++)
                hdr = hdr | (HDR_W'(ring_mem[ADDR_W'(rd_ptr + i)]) << (8 * i));
            if (hdr > MAX_RECORD || hdr > fill_level - HEADER_BYTES)
            begin
                rd_ptr     = wr_ptr;
                fill_level = '0;
                rd_left    = '0;
                r.status   = STAT_CORRUPT;
                return r;
            end
            rd_span = SIZE_W'(HEADER_BYTES + hdr);
            rd_next = ADDR_W'(rd_ptr + rd_span);
            rd_pos  = ADDR_W'(rd_ptr + HEADER_BYTES);
            deliver = (hdr < item.rd_limit) ? MIN_W'(hdr) : MIN_W'(item.rd_limit);
            if (deliver == 0)
            begin
                release_record();
                r.rd_last = 1'b1;
                return r;
            end
            rd_left = deliver;
        end
        else if (rd_left == 0)
            return r;
        r.rd_byte  = ring_mem[rd_pos];
        r.rd_valid = 1'b1;
        r.status   = STAT_DELIVERED;
        rd_pos     = rd_pos + 1'b1;
        rd_left    = rd_left - 1'b1;
        if (rd_left == 0)
        begin
            release_record();
            r.rd_last = 1'b1;
        end
        return r;
    endfunction

    function automatic req_t next_random_item();
        req_t        it;
        int unsigned pick;
        int unsigned shape;
        it.opcode    = ($urandom_range(99) < 55) ? OP_WRITE : OP_READ;
        it.wr_byte   = 8'($urandom);
        it.wr_first  = 1'($urandom);
        it.wr_length = 16'($urandom);
        it.rd_first  = 1'($urandom);
        it.rd_limit  = 13'($urandom_range(4096));
        pick  = $urandom_range(99);
        shape = $urandom_range(99);
        if (it.opcode == OP_WRITE)
        begin
            // mostly continue the open record, sometimes abandon it or send a stray byte
            it.wr_first = (wr_left != 0) ? (pick < 8) : (pick < 90);
            if (it.wr_first)
            begin
                if (shape < 5)
                    it.wr_length = '0;
                else if (shape < 80)
                    it.wr_length = 16'($urandom_range(24, 1));
                else if (shape < 97)
                    it.wr_length = 16'($urandom_range(200, 25));
                else
                    it.wr_length = 16'($urandom_range(1000, 201));
            end
        end
        else
        begin
            it.rd_first = (rd_left != 0) ? (pick < 12) : (pick < 85);
            if (it.rd_first)
            begin
                if (shape < 8)
                    it.rd_limit = '0;
                else if (shape < 98)
                    it.rd_limit = 13'($urandom_range(30, 1));
                else
                    it.rd_limit = 13'(MAX_RECORD);
            end
        end
        return it;
    endfunction

    task automatic issue(input req_t item, input logic known, input rsp_t want);
        rsp_t predicted;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = ring_response(item);
        awaited_rsp.push_back(known ? want : predicted);
    endtask

    task automatic write_record(input int unsigned length_field);
        int unsigned count;
        count = (length_field > MAX_RECORD) ? MAX_RECORD : length_field;
        issue(wr_op(1'b1, length_field, 8'($urandom)), 1'b0, NO_RSP);
        repeat (count - 1)
            issue(wr_op(1'b0, $urandom, 8'($urandom)), 1'b0, NO_RSP);
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            $error("rsp transfer with nothing expected: %h", got);
            mismatches++;
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.rd_byte !== want.rd_byte)
        begin
            $error("rd_byte: expected %0h, got %0h", want.rd_byte, got.rd_byte);
            mismatches++;
        end
        if (got.rd_valid !== want.rd_valid)
        begin
            $error("rd_valid: expected %0b, got %0b", want.rd_valid, got.rd_valid);
            mismatches++;
        end
        if (got.rd_last !== want.rd_last)
        begin
            $error("rd_last: expected %0b, got %0b", want.rd_last, got.rd_last);
            mismatches++;
        end
        if (got.committed !== want.committed)
        begin
            $error("committed: expected %0b, got %0b", want.committed, got.committed);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_response(rsp);
        rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        int unsigned counted;
        logic        idle_item;
        req_t        item;

        script[0]  = {rd_op(1'b1, 5),            1'b1,
                      outcome(8'h00, 1'b0, 1'b0, 1'b0, STAT_EMPTY)};
        script[1]  = {rd_op(1'b0, 0),            1'b1, NO_RSP};
        script[2]  = {wr_op(1'b0, 7, 8'hFF),     1'b1, NO_RSP};
        script[3]  = {wr_op(1'b1, 0, 8'h44),     1'b1, NO_RSP};
        script[4]  = {wr_op(1'b1, 3, 8'h00),     1'b1, NO_RSP};
        script[5]  = {wr_op(1'b0, 0, 8'hFF),     1'b1, NO_RSP};
        script[6]  = {wr_op(1'b0, 0, 8'hA5),     1'b1,
                      outcome(8'h00, 1'b0, 1'b0, 1'b1, STAT_OK)};
        script[7]  = {wr_op(1'b1, 1, 8'h5A),     1'b1,
                      outcome(8'h00, 1'b0, 1'b0, 1'b1, STAT_OK)};
        script[8]  = {wr_op(1'b1, 65535, 8'h11), 1'b1, NO_RSP};
        script[9]  = {wr_op(1'b1, 2, 8'h22),     1'b1, NO_RSP};
        script[10] = {wr_op(1'b0, 0, 8'h33),     1'b1,
                      outcome(8'h00, 1'b0, 1'b0, 1'b1, STAT_OK)};
        script[11] = {rd_op(1'b1, 0),            1'b1,
                      outcome(8'h00, 1'b0, 1'b1, 1'b0, STAT_OK)};
        script[12] = {rd_op(1'b1, 4096),         1'b1,
                      outcome(8'h5A, 1'b1, 1'b1, 1'b0, STAT_DELIVERED)};
        script[13] = {rd_op(1'b1, 1),            1'b1,
                      outcome(8'h22, 1'b1, 1'b1, 1'b0, STAT_DELIVERED)};
        script[14] = {rd_op(1'b1, 4095),         1'b1,
                      outcome(8'h00, 1'b0, 1'b0, 1'b0, STAT_EMPTY)};
        script[15] = {wr_op(1'b1, 4, 8'h01),     1'b0, NO_RSP};
        script[16] = {wr_op(1'b0, 0, 8'h80),     1'b0, NO_RSP};
        script[17] = {wr_op(1'b0, 0, 8'h7F),     1'b0, NO_RSP};
        script[18] = {wr_op(1'b0, 0, 8'hFE),     1'b0, NO_RSP};
        script[19] = {wr_op(1'b1, 2, 8'hC3),     1'b0, NO_RSP};
        script[20] = {wr_op(1'b0, 0, 8'h3C),     1'b0, NO_RSP};
        script[21] = {rd_op(1'b1, 4095),         1'b0, NO_RSP};
        script[22] = {rd_op(1'b0, 0),            1'b0, NO_RSP};
        script[23] = {rd_op(1'b1, 2),            1'b0, NO_RSP};
        script[24] = {rd_op(1'b0, 0),            1'b0, NO_RSP};
        script[25] = {rd_op(1'b0, 0),            1'b0, NO_RSP};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            issue(script[i].item, script[i].known, script[i].want);

        // back-to-back stretch with no idling: whole records in and out, then a read cut short
        calm <= 1'b1;
        repeat (4)
            write_record($urandom_range(40, 8));
        repeat (2)
        begin
            issue(rd_op(1'b1, MAX_RECORD), 1'b0, NO_RSP);
            while (rd_left != 0)
                issue(rd_op(1'b0, 0), 1'b0, NO_RSP);
        end
        issue(rd_op(1'b1, 3), 1'b0, NO_RSP);
        repeat (5)
            issue(rd_op(1'b0, 0), 1'b0, NO_RSP);
        calm <= 1'b0;

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            item = next_random_item();
            if (item.opcode == OP_WRITE)
                idle_item = !item.wr_first && wr_left == 0;
            else
                idle_item = !item.rd_first && rd_left == 0;
            issue(item, 1'b0, NO_RSP);
            if (!idle_item)
                counted++;
        end
        req_valid <= 1'b0;

        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("length_prefixed_record_ring regression: pass");
        else
            $display("length_prefixed_record_ring regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/lprr_pkg.sv
rtl/core/length_prefixed_record_ring.sv
sim/tb_top.sv
